FILE: hw/rtl/wto_pkg.sv
// Shared constants and types for the wavetable oscillator.
// Command codes, register indexes and field widths. No dependencies.
`timescale 1ns / 1ps

package wto_pkg;

    // Field widths of the item, result and configuration beats
    localparam int CMD_W      = 2;
    localparam int TNUM_W     = 3;
    localparam int TADDR_W    = 11;
    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 32;
    localparam int TSEL_W     = 3;
    localparam int TIU_W      = 4;
    localparam int LEN_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [CMD_W-1:0]           cmd_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    // Item commands
    localparam cmd_t CMD_TICK      = 2'd0;
    localparam cmd_t CMD_WRITE     = 2'd1;
    localparam cmd_t CMD_SET_PHASE = 2'd2;

    // Configuration register indexes
    localparam cfg_idx_t REG_PHASE_INC  = 3'd0;
    localparam cfg_idx_t REG_TABLE_SEL  = 3'd1;
    localparam cfg_idx_t REG_TABLES_USE = 3'd2;
    localparam cfg_idx_t REG_TABLE_LEN  = 3'd3;
    localparam cfg_idx_t REG_ACTIVE     = 3'd4;

endpackage

FILE: hw/rtl/wto_if.sv
// Channel interfaces of the wavetable oscillator: item, result, configuration.
// Depends on wto_pkg for field widths and types.
`timescale 1ns / 1ps

// Item channel: tick, table write, set phase
interface wto_item_if import wto_pkg::*; ();
    logic                 valid;
    logic                 ready;
    cmd_t                 command;
    logic [TNUM_W-1:0]    table_number;
    logic [TADDR_W-1:0]   table_address;
    sample_t              sample_value;
    logic [PHASE_W-1:0]   phase_value;

    modport source (output valid, command, table_number, table_address,
                    sample_value, phase_value, input ready);
    modport sink   (input valid, command, table_number, table_address,
                    sample_value, phase_value, output ready);
endinterface

// Result channel: one sample per tick
interface wto_result_if import wto_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

// Configuration write channel
interface wto_cfg_if import wto_pkg::*; ();
    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/wavetable_oscillator_linear_interp.sv
// Wavetable oscillator top level: table bank RAM, phase accumulator, interpolation.
// Depends on wto_pkg and the channel interfaces in wto_if.sv.
//
//   channel   dir   payload                                              beat taken when
//   -------   ---   ---------------------------------------------------  ---------------
//   cfg       in    index, data                                          valid (ready=1)
//   item      in    command, table_number, table_address,                valid && ready
//                   sample_value, phase_value
//   result    out   sample                                               valid && ready
//
// Table writes and set-phase beats keep the block idle. An active, non-silent tick steps
// through RD0, RD1, MUL and OUT: the two table entries are read one after the other
// through the single read port of the bank RAM, then one multiply stage and one sum
// stage. Silent or inactive ticks skip to OUT. Reset clears phase, configuration
// registers and handshake state; the table RAM holds whatever was last written.
// A result waiting in the output register does not block new beats, but a
// finished tick holds in its last step until the output register is free.
`timescale 1ns / 1ps

module wavetable_oscillator_linear_interp import wto_pkg::*; #(
    parameter int NUM_TABLES  = 8,
    parameter int TABLE_DEPTH = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    wto_cfg_if.sink      cfg,
    wto_item_if.sink     item,
    wto_result_if.source result
);

    localparam int BANK = NUM_TABLES * TABLE_DEPTH;
    localparam int AW   = $clog2(BANK);
    localparam int CW   = AW + 13;
    localparam int SB   = SAMPLE_BITS;
    localparam int PW   = SB + 18;
    localparam int POSW = PHASE_W + LEN_W;

    localparam logic [6:0]  NUM_TABLES_L  = 7'(NUM_TABLES);
    localparam logic [16:0] TABLE_DEPTH_L = 17'(TABLE_DEPTH);

    // Sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // Configuration registers
    logic [PHASE_W-1:0] phase_inc_reg;
    logic [TSEL_W-1:0]  tsel_reg;
    logic [TIU_W-1:0]   tiu_reg;
    logic [LEN_W-1:0]   tlen_reg;
    logic               active_reg;

    // Control and datapath registers
    logic [2:0]         state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [POSW-1:0]    pos_reg;
    logic [TSEL_W-1:0]  sel_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               zero_reg;
    logic [SB-1:0]      s0_reg;
    logic signed [PW-1:0] prod_reg;
    logic               out_valid_reg, out_valid_next;
    sample_t            out_sample_reg;

    // Table bank
    logic [SB-1:0]      mem [BANK];
    logic [SB-1:0]      rd_data_reg;

    logic item_beat;
    logic tick_beat;
    logic out_free;

    assign cfg.ready     = 1'b1;
    assign item.ready    = (state_reg == S_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.sample = out_sample_reg;

    assign item_beat = item.valid && item.ready;
    assign tick_beat = item_beat && (item.command == CMD_TICK);
    assign out_free  = !out_valid_reg || result.ready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg <= '0;
            tsel_reg      <= '0;
            tiu_reg       <= '0;
            tlen_reg      <= '0;
            active_reg    <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PHASE_INC:  phase_inc_reg <= cfg.data;
                REG_TABLE_SEL:  tsel_reg      <= cfg.data[TSEL_W-1:0];
                REG_TABLES_USE: tiu_reg       <= cfg.data[TIU_W-1:0];
                REG_TABLE_LEN:  tlen_reg      <= cfg.data[LEN_W-1:0];
                REG_ACTIVE:     active_reg    <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Effective table count, length and selection after clamping
    logic [TIU_W-1:0]  n_eff;
    logic [LEN_W-1:0]  len_eff;
    logic [TSEL_W-1:0] sel_eff;
    logic              silent;

    always_comb
    begin
        if (7'(tiu_reg) > NUM_TABLES_L)
            n_eff = TIU_W'(NUM_TABLES);
        else
            n_eff = tiu_reg;
        if (17'(tlen_reg) > TABLE_DEPTH_L)
            len_eff = LEN_W'(TABLE_DEPTH);
        else
            len_eff = tlen_reg;
        if ({1'b0, tsel_reg} >= n_eff)
            sel_eff = TSEL_W'(n_eff - 4'd1);
        else
            sel_eff = tsel_reg;
        silent = (n_eff == '0) || (len_eff == '0);
    end

    // Table write: out-of-range table or entry is dropped
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [SB-1:0] wr_data;
    logic [CW-1:0] wr_addr_w;
    logic [47:0]   wr_ext;

    always_comb
    begin
        wr_en = item_beat && (item.command == CMD_WRITE)
                && (7'(item.table_number) < NUM_TABLES_L)
                && (17'(item.table_address) < TABLE_DEPTH_L);
        wr_addr_w = CW'(item.table_number) * CW'(TABLE_DEPTH) + CW'(item.table_address);
        wr_addr   = wr_addr_w[AW-1:0];
        // entry is the low SAMPLE_BITS bits, zero-extended when wider than the field
        wr_ext  = {32'd0, item.sample_value};
        wr_data = wr_ext[SB-1:0];
    end

    // Read address of the current or next entry
    logic [LEN_W-1:0] i0;
    logic [LEN_W:0]   i1_w;
    logic [LEN_W-1:0] i0_sel;
    logic [LEN_W-1:0] i1_sel;
    logic             rd_en;
    logic [CW-1:0]    rd_addr_w;
    logic [AW-1:0]    rd_addr;

    always_comb
    begin
        i0   = pos_reg[POSW-1:PHASE_W];
        i1_w = {1'b0, i0} + 13'd1;
        if (i0 >= len_reg)
            i0_sel = '0;
        else
            i0_sel = i0;
        if (i1_w >= {1'b0, len_reg})
            i1_sel = '0;
        else
            i1_sel = i1_w[LEN_W-1:0];
        rd_en     = (state_reg == S_RD0) || (state_reg == S_RD1);
        rd_addr_w = CW'(sel_reg) * CW'(TABLE_DEPTH)
                    + CW'((state_reg == S_RD1) ? i1_sel : i0_sel);
        rd_addr   = rd_addr_w[AW-1:0];
    end

    // Bank RAM, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (tick_beat)
                begin
                    if (!active_reg || silent)
                        state_next = S_OUT;
                    else
                        state_next = S_RD0;
                end
            end
            S_RD0: state_next = S_RD1;
            S_RD1: state_next = S_MUL;
            S_MUL: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (state_reg == S_OUT && out_free)
            out_valid_next = 1'b1;
    end

    // Control state and phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (item_beat && item.command == CMD_SET_PHASE)
                phase_reg <= item.phase_value;
            else if (tick_beat && active_reg)
                phase_reg <= phase_reg + phase_inc_reg;
        end
    end

    // Interpolation datapath
    logic signed [SB:0]   diff_w;
    logic signed [PW-1:0] sum_w;

    always_comb
    begin
        diff_w = $signed({rd_data_reg[SB-1], rd_data_reg}) - $signed({s0_reg[SB-1], s0_reg});
        // arithmetic shift gives the floor of the scaled step
        sum_w  = PW'($signed(s0_reg)) + (prod_reg >>> 16);
    end

    always_ff @(posedge clk)
    begin
        if (tick_beat)
        begin
            pos_reg  <= POSW'(phase_reg) * POSW'(len_eff);
            sel_reg  <= sel_eff;
            len_reg  <= len_eff;
            zero_reg <= !active_reg || silent;
        end
        if (state_reg == S_RD1)
            s0_reg <= rd_data_reg;
        if (state_reg == S_MUL)
            prod_reg <= PW'($signed({1'b0, pos_reg[31:16]}) * diff_w);
        if (state_reg == S_OUT && out_free)
            out_sample_reg <= zero_reg ? sample_t'(0) : sample_t'(sum_w[SAMPLE_W-1:0]);
    end

endmodule

FILE: hw/rtl/wto_checker.sv
// Port-level checks for the wavetable oscillator, bound to the top level.
// Depends on wto_pkg for command codes.
`timescale 1ns / 1ps

module wto_checker import wto_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input cmd_t    item_command,
    input logic    result_valid,
    input logic    result_ready,
    input sample_t result_sample
);

    logic item_beat;
    assign item_beat = item_valid && item_ready;

    // A stalled result keeps its sample
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_sample))
        else $error("result changed while stalled");

    // No beat produces a result in the very next cycle
    a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_beat && !result_valid |=> !result_valid)
        else $error("result appeared one cycle after an item beat");

    // A tick occupies the block: no new item beat right after it
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_beat && item_command == CMD_TICK |=> !item_ready)
        else $error("item taken while a tick is in progress");

    // A cycle spent in reset leaves no result pending
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid after reset");

endmodule

bind wavetable_oscillator_linear_interp wto_checker u_wto_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .item_command  (item.command),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_sample (result.sample)
);
